// ===== rtl/msep_pkg.sv =====
`default_nettype none

package msep_pkg;

  // result kinds
  localparam logic [2:0] KIND_NOTE_OFF  = 3'd0;
  localparam logic [2:0] KIND_NOTE_ON   = 3'd1;
  localparam logic [2:0] KIND_BEND      = 3'd2;
  localparam logic [2:0] KIND_WAIT      = 3'd3;
  localparam logic [2:0] KIND_SCORE_END = 3'd4;
  localparam logic [2:0] KIND_STOPPED   = 3'd5;

  // descriptor event types
  localparam logic [2:0] EV_RELEASE = 3'd0;
  localparam logic [2:0] EV_PRESS   = 3'd1;
  localparam logic [2:0] EV_BEND    = 3'd2;
  localparam logic [2:0] EV_CTRL    = 3'd4;
  localparam logic [2:0] EV_MEASURE = 3'd5;
  localparam logic [2:0] EV_FINISH  = 3'd6;

  localparam logic [6:0] CTRL_VOLUME = 7'd3;
  localparam logic [6:0] TABLE_INIT  = 7'd100;
  localparam logic [3:0] PERC_CHAN   = 4'd15;

  // result queue
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = 2;
  localparam int RES_CNT_W = 3;

  // decoded byte: up to one event plus an optional stopped marker, and table updates
  typedef struct packed {
    logic        ev_valid;
    logic [2:0]  ev_kind;
    logic [3:0]  ev_chan;
    logic [6:0]  ev_note;
    logic        vel_explicit;
    logic [6:0]  ev_vel;
    logic        use_tables;
    logic [7:0]  ev_bend;
    logic [31:0] ev_delay;
    logic        ev_looped;
    logic        stop_valid;
    logic        vel_we;
    logic        vol_we;
    logic [6:0]  wr_data;
    logic        clear_tables;
  } msep_op_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  channel;
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [6:0]  level;
    logic [7:0]  bend;
    logic [31:0] delay;
    logic        perc;
    logic        looped;
    logic        last;
  } msep_res_t;

endpackage

`default_nettype wire

// ===== rtl/msep_parser.sv =====
`default_nettype none

module msep_parser
  import msep_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       acc,
  input  wire logic [7:0] score_byte,
  input  wire logic       start_of_score,
  input  wire logic       final_byte,
  input  wire logic       loop_enable,
  output msep_op_t        op,
  output logic [3:0]      rd_chan
);

  typedef enum logic [7:0] {
    PH_DESC        = 8'b0000_0001,
    PH_OFF_NOTE    = 8'b0000_0010,
    PH_ON_NOTE     = 8'b0000_0100,
    PH_ON_VOL      = 8'b0000_1000,
    PH_ONE_OPERAND = 8'b0001_0000,
    PH_CTRL_NUM    = 8'b0010_0000,
    PH_CTRL_VAL    = 8'b0100_0000,
    PH_DELAY       = 8'b1000_0000
  } msep_phase_t;

  msep_phase_t phase, phase_next;
  logic [2:0]  code, code_next;
  logic [3:0]  chan, chan_next;
  logic        glast, glast_next;
  logic [6:0]  held, held_next;
  logic [31:0] dsum, dsum_next;
  logic        halted, halted_next;

  assign rd_chan = chan;

  always_comb begin
    logic ended;
    ended       = 1'b0;
    op          = '0;
    phase_next  = phase;
    code_next   = code;
    chan_next   = chan;
    glast_next  = glast;
    held_next   = held;
    dsum_next   = dsum;
    halted_next = halted;

    if (start_of_score) begin
      phase_next  = PH_DESC;
      code_next   = '0;
      chan_next   = '0;
      glast_next  = 1'b0;
      held_next   = '0;
      dsum_next   = '0;
      halted_next = 1'b0;
    end

    if (!halted_next) begin
      op.ev_chan = chan_next;
      case (phase_next)
        PH_DESC: begin
          glast_next = score_byte[7];
          code_next  = score_byte[6:4];
          chan_next  = score_byte[3:0];
          op.ev_chan = score_byte[3:0];
          dsum_next  = '0;
          case (score_byte[6:4])
            EV_RELEASE: phase_next = PH_OFF_NOTE;
            EV_PRESS:   phase_next = PH_ON_NOTE;
            EV_CTRL:    phase_next = PH_CTRL_NUM;
            EV_MEASURE: phase_next = score_byte[7] ? PH_DELAY : PH_DESC;
            EV_FINISH: begin
              op.ev_valid  = 1'b1;
              op.ev_kind   = KIND_SCORE_END;
              op.ev_looped = loop_enable;
              ended        = 1'b1;
              if (loop_enable) begin
                op.clear_tables = 1'b1;
              end else begin
                halted_next = 1'b1;
              end
              phase_next = PH_DESC;
            end
            default:    phase_next = PH_ONE_OPERAND;
          endcase
        end
        PH_OFF_NOTE: begin
          op.ev_valid = 1'b1;
          op.ev_kind  = KIND_NOTE_OFF;
          op.ev_note  = score_byte[6:0];
          dsum_next   = '0;
          phase_next  = glast ? PH_DELAY : PH_DESC;
        end
        PH_ON_NOTE: begin
          held_next = score_byte[6:0];
          if (score_byte[7]) begin
            phase_next = PH_ON_VOL;
          end else begin
            op.ev_valid   = 1'b1;
            op.ev_kind    = KIND_NOTE_ON;
            op.ev_note    = score_byte[6:0];
            op.use_tables = 1'b1;
            dsum_next     = '0;
            phase_next    = glast ? PH_DELAY : PH_DESC;
          end
        end
        PH_ON_VOL: begin
          op.vel_we       = 1'b1;
          op.wr_data      = score_byte[6:0];
          op.ev_valid     = 1'b1;
          op.ev_kind      = KIND_NOTE_ON;
          op.ev_note      = held;
          op.vel_explicit = 1'b1;
          op.ev_vel       = score_byte[6:0];
          op.use_tables   = 1'b1;
          dsum_next       = '0;
          phase_next      = glast ? PH_DELAY : PH_DESC;
        end
        PH_ONE_OPERAND: begin
          if (code == EV_BEND) begin
            op.ev_valid = 1'b1;
            op.ev_kind  = KIND_BEND;
            op.ev_bend  = score_byte;
          end
          dsum_next  = '0;
          phase_next = glast ? PH_DELAY : PH_DESC;
        end
        PH_CTRL_NUM: begin
          held_next  = score_byte[6:0];
          phase_next = PH_CTRL_VAL;
        end
        PH_CTRL_VAL: begin
          op.vol_we  = (held == CTRL_VOLUME);
          op.wr_data = score_byte[6:0];
          dsum_next  = '0;
          phase_next = glast ? PH_DELAY : PH_DESC;
        end
        PH_DELAY: begin
          // variable-length quantity, seven bits per byte
          dsum_next = {dsum[24:0], score_byte[6:0]};
          if (!score_byte[7]) begin
            op.ev_valid = 1'b1;
            op.ev_kind  = KIND_WAIT;
            op.ev_delay = {dsum[24:0], score_byte[6:0]};
            phase_next  = PH_DESC;
          end
        end
        default: phase_next = PH_DESC;
      endcase

      if (final_byte && !ended) begin
        op.stop_valid = 1'b1;
        halted_next   = 1'b1;
        phase_next    = PH_DESC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_DESC;
      code   <= '0;
      chan   <= '0;
      glast  <= 1'b0;
      held   <= '0;
      dsum   <= '0;
      halted <= 1'b1;
    end else if (acc) begin
      phase  <= phase_next;
      code   <= code_next;
      chan   <= chan_next;
      glast  <= glast_next;
      held   <= held_next;
      dsum   <= dsum_next;
      halted <= halted_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/msep_res_fifo.sv =====
`default_nettype none

module msep_res_fifo
  import msep_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [1:0]           push_n,
  input  wire msep_res_t            push_d0,
  input  wire msep_res_t            push_d1,
  input  wire logic                 pop,
  output msep_res_t                 head,
  output logic                      not_empty,
  output logic [RES_CNT_W-1:0]      count
);

  msep_res_t            mem [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr;
  logic [RES_PTR_W-1:0] rd_ptr;

  assign head      = mem[rd_ptr];
  assign not_empty = (count != '0);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= push_d0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr + RES_PTR_W'(1)] <= push_d1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RES_PTR_W'(push_n);
      rd_ptr <= rd_ptr + RES_PTR_W'(pop);
      count  <= count + RES_CNT_W'(push_n) - RES_CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mus_score_event_parser.sv =====
`default_nettype none

// MUS score event parser. Score bytes enter on the slave stream one per beat and
// the block takes a new byte every cycle while its four-entry result queue has
// room; a byte's results pass through the resolve stage into the result queue. The per-channel
// volume and velocity tables sit in synchronous memories read once per byte at
// the channel of the current event, registered alongside the resolve stage. A byte
// that ends the data without ending the score gives its event, if any, and a
// stopped event, each in its own output beat. After reset the block ignores
// bytes until one arrives with tuser (start of score) set. The tables need no
// clearing pass: per-entry valid bits make a cleared entry read 100.
module mus_score_event_parser
  import msep_pkg::*;
#(
  parameter int CHANNEL_COUNT = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,     // loop_enable
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,       // score_byte
  input  wire logic        s_tuser,       // start_of_score
  input  wire logic        s_tlast,       // final_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // channel[3:0], note[10:4], velocity[17:11], channel_level[24:18],
  // bend_value[32:25], delay_ticks[64:33], percussion[65], looped[66], zero[71:67]
  output logic [71:0]      m_tdata,
  output logic [2:0]       m_tuser,       // event_kind
  output logic             m_tlast        // last_result
);

  localparam int ADDR_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

  logic loop_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_enable <= 1'b0;
    end else if (cfg_we) begin
      loop_enable <= cfg_wdata;
    end
  end

  logic     acc;
  msep_op_t op;
  logic [3:0] rd_chan;

  assign acc = s_tvalid && s_tready;

  msep_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .acc            (acc),
    .score_byte     (s_tdata),
    .start_of_score (s_tuser),
    .final_byte     (s_tlast),
    .loop_enable    (loop_enable),
    .op             (op),
    .rd_chan        (rd_chan)
  );

  // channel tables
  logic [6:0] vol_mem [CHANNEL_COUNT];
  logic [6:0] vel_mem [CHANNEL_COUNT];
  logic [CHANNEL_COUNT-1:0] vol_ok;
  logic [CHANNEL_COUNT-1:0] vel_ok;

  logic              in_range;
  logic [ADDR_W-1:0] addr;
  logic              clear_now;
  logic              vol_wr;
  logic              vel_wr;

  assign in_range  = ({1'b0, rd_chan} < 5'(CHANNEL_COUNT));
  assign addr      = rd_chan[ADDR_W-1:0];
  assign clear_now = acc && (s_tuser || op.clear_tables);
  assign vol_wr    = acc && op.vol_we && in_range;
  assign vel_wr    = acc && op.vel_we && in_range;

  always_ff @(posedge clk) begin
    if (vol_wr) begin
      vol_mem[addr] <= op.wr_data;
    end
    if (vel_wr) begin
      vel_mem[addr] <= op.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_now) begin
      vol_ok <= '0;
      vel_ok <= '0;
    end else begin
      if (vol_wr) begin
        vol_ok[addr] <= 1'b1;
      end
      if (vel_wr) begin
        vel_ok[addr] <= 1'b1;
      end
    end
  end

  // registered table read, a start of score wipes the tables before this byte
  logic [6:0] rd_vol;
  logic [6:0] rd_vel;
  logic       rd_vol_hit;
  logic       rd_vel_hit;

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_vol     <= vol_mem[addr];
      rd_vel     <= vel_mem[addr];
      rd_vol_hit <= in_range && vol_ok[addr] && !s_tuser;
      rd_vel_hit <= in_range && vel_ok[addr] && !s_tuser;
    end
  end

  // resolve stage
  logic     s1_valid;
  msep_op_t s1_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= acc && (op.ev_valid || op.stop_valid);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_op <= op;
    end
  end

  logic [1:0] s1_n;
  msep_res_t  ev_res;
  msep_res_t  stop_res;
  msep_res_t  slot0;
  msep_res_t  slot1;

  assign s1_n = s1_valid ? ({1'b0, s1_op.ev_valid} + {1'b0, s1_op.stop_valid}) : 2'd0;

  always_comb begin
    ev_res          = '0;
    ev_res.kind     = s1_op.ev_kind;
    ev_res.channel  = s1_op.ev_chan;
    ev_res.note     = s1_op.ev_note;
    ev_res.bend     = s1_op.ev_bend;
    ev_res.delay    = s1_op.ev_delay;
    ev_res.perc     = (s1_op.ev_chan == PERC_CHAN);
    ev_res.looped   = s1_op.ev_looped;
    ev_res.last     = !s1_op.stop_valid;
    if (s1_op.use_tables) begin
      ev_res.level    = rd_vol_hit ? rd_vol : TABLE_INIT;
      ev_res.velocity = s1_op.vel_explicit ? s1_op.ev_vel
                                           : (rd_vel_hit ? rd_vel : TABLE_INIT);
    end

    stop_res      = '0;
    stop_res.kind = KIND_STOPPED;
    stop_res.last = 1'b1;

    slot0 = s1_op.ev_valid ? ev_res : stop_res;
    slot1 = stop_res;
  end

  msep_res_t             head;
  logic [RES_CNT_W-1:0]  fifo_count;
  logic                  pop;

  assign pop = m_tvalid && m_tready;

  msep_res_fifo u_res_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_n    (s1_n),
    .push_d0   (slot0),
    .push_d1   (slot1),
    .pop       (pop),
    .head      (head),
    .not_empty (m_tvalid),
    .count     (fifo_count)
  );

  // room for whatever is in flight plus two more
  assign s_tready = ({1'b0, fifo_count} + 4'(s1_n)) <= 4'(RES_DEPTH - 2);

  assign m_tdata = {5'b0, head.looped, head.perc, head.delay, head.bend, head.level,
                    head.velocity, head.note, head.channel};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

`ifndef NO_ASSERTIONS
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> ({1'b0, fifo_count} + 4'(s1_n)) <= 4'(RES_DEPTH))
    else $error("result queue overflow");

  a_stop_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_STOPPED) |-> (m_tlast && m_tdata == '0))
    else $error("stopped event not clean");

  a_write_no_clear: assert property (@(posedge clk) disable iff (rst)
    (vol_wr || vel_wr) |-> !clear_now)
    else $error("table write during clear");
`endif

endmodule

`default_nettype wire
